### rtl/tsse_pkg.sv
`timescale 1ns / 1ps
package tsse_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int DIM_W    = 13;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [35:0] LN2_Q30 = 36'd744261118;
    localparam logic [60:0] NUM_ONE = 61'h1 << 60;

    localparam int EXP_UNITS    = 2;
    localparam int DIV_UNITS    = 3;
    localparam int HORNER_STEPS = 9;
    localparam int EXP_CARRY    = 3 * HORNER_STEPS + 2;
    localparam int ER_LEN       = 3 * HORNER_STEPS - 2;
    localparam int EXP_LAT      = EXP_CARRY + 1;
    localparam int QBITS        = 31;
    localparam int DIV_LAT      = QBITS;
    localparam int DEN_W        = 47;
    localparam int NUM_W        = 61;

    localparam int ST_T    = EXP_LAT + DIV_LAT;
    localparam int ST_X    = ST_T + 2;
    localparam int ST_E1   = ST_X + EXP_LAT;
    localparam int ST_S    = ST_E1 + DIV_LAT;
    localparam int ST_OUT  = ST_S + 7;
    localparam int XDL_LEN = ST_E1 - ST_T;
    localparam int QDL_LEN = ST_E1 - ST_X;
    localparam int TDL_LEN = ST_S - ST_T;
    localparam int PROB_LEN = ST_OUT - ST_S - 1;

    localparam logic [2:0] REG_GAIN        = 3'd0;
    localparam logic [2:0] REG_THRESHOLD   = 3'd1;
    localparam logic [2:0] REG_BETA        = 3'd2;
    localparam logic [2:0] REG_SOURCE_SIZE = 3'd3;
    localparam logic [2:0] REG_TARGET_SIZE = 3'd4;

    typedef struct packed {
        logic        pad;
        logic        s_neg;
        logic        u_neg;
        logic [15:0] u_mag;
    } side_t;

    function automatic logic [35:0] ln2_mult(input logic [4:0] k);
        ln2_mult = 36'(k) * LN2_Q30;
    endfunction

    // floor(2^33 / d)
    function automatic logic [33:0] recip_q33(input logic [3:0] d);
        case (d)
            4'd1:    recip_q33 = 34'd8589934592;
            4'd2:    recip_q33 = 34'd4294967296;
            4'd3:    recip_q33 = 34'd2863311530;
            4'd4:    recip_q33 = 34'd2147483648;
            4'd5:    recip_q33 = 34'd1717986918;
            4'd6:    recip_q33 = 34'd1431655765;
            4'd7:    recip_q33 = 34'd1227133513;
            4'd8:    recip_q33 = 34'd1073741824;
            4'd9:    recip_q33 = 34'd954437176;
            4'd10:   recip_q33 = 34'd858993459;
            default: recip_q33 = '0;
        endcase
    endfunction

    // estimate of v / d, low by at most one
    function automatic logic [30:0] quot_est(input logic [30:0] v, input logic [3:0] d);
        quot_est = 31'((65'(v) * 65'(recip_q33(d))) >> 33);
    endfunction

    function automatic logic [30:0] quot_fix(input logic [30:0] v, input logic [30:0] q0,
                                             input logic [3:0] d);
        logic [30:0] rem;
        rem = v - 31'(35'(q0) * 35'(d));
        quot_fix = (rem >= 31'(d)) ? q0 + 31'd1 : q0;
    endfunction

endpackage

### rtl/tanh_sigmoid_spike_encoder_gradient_top.sv
`timescale 1ns / 1ps
// Soft spike encoder with surrogate gradient. One element is taken on every clock
// (busy never rises) and its result appears with done, in order; done is a one-cycle
// strobe and the receiver cannot stall.
// The pipeline holds two exponential units (range reduction plus a nine-step
// series, three stages a step) and two rounds of 31-stage restoring dividers
// (tanh, then sigmoid and surrogate side by side), followed by the gradient products.
// Configuration writes are always ready and must only occur with no element in flight.
module tanh_sigmoid_spike_encoder_gradient_top
    import tsse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [11:0]        element_index,
    input  logic signed [15:0] source_value,
    input  logic signed [15:0] upstream_grad,
    output logic               done,
    output logic [15:0]        fire_prob,
    output logic signed [23:0] source_grad,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic [15:0]      gain_reg;
    logic [15:0]      threshold_reg;
    logic [15:0]      beta_reg;
    logic [DIM_W-1:0] source_size_reg;
    logic [DIM_W-1:0] target_size_reg;

    logic [ST_OUT:0]  vld_reg;
    side_t            side_reg [ST_OUT];
    side_t            side_next;
    logic [DIM_W-1:0] dim;
    logic [15:0]      smag_reg;
    logic [15:0]      smag_next;

    // exponential units
    logic [38:0] ex_y    [EXP_UNITS];
    logic [38:0] ey_reg  [EXP_UNITS];
    logic [38:0] ey_next [EXP_UNITS];
    logic [4:0]  ek_reg  [EXP_UNITS][EXP_CARRY];
    logic [4:0]  ek_next [EXP_UNITS][EXP_CARRY];
    logic        ez_reg  [EXP_UNITS][EXP_CARRY];
    logic        ez_next [EXP_UNITS][EXP_CARRY];
    logic [29:0] er_reg  [EXP_UNITS][ER_LEN];
    logic [29:0] er_next [EXP_UNITS][ER_LEN];
    logic [29:0] hv_reg  [EXP_UNITS][HORNER_STEPS];
    logic [29:0] hv_next [EXP_UNITS][HORNER_STEPS];
    logic [29:0] hw_reg  [EXP_UNITS][HORNER_STEPS];
    logic [29:0] hw_next [EXP_UNITS][HORNER_STEPS];
    logic [30:0] hq_reg  [EXP_UNITS][HORNER_STEPS];
    logic [30:0] hq_next [EXP_UNITS][HORNER_STEPS];
    logic [30:0] hp_reg  [EXP_UNITS][HORNER_STEPS];
    logic [30:0] hp_next [EXP_UNITS][HORNER_STEPS];
    logic [30:0] e_reg   [EXP_UNITS];
    logic [30:0] e_next  [EXP_UNITS];

    // dividers
    logic [NUM_W-1:0] dv_n     [DIV_UNITS];
    logic [DEN_W-1:0] dv_d     [DIV_UNITS];
    logic [DEN_W-1:0] dvr_reg  [DIV_UNITS][QBITS];
    logic [DEN_W-1:0] dvr_next [DIV_UNITS][QBITS];
    logic [30:0]      dvn_reg  [DIV_UNITS][QBITS];
    logic [30:0]      dvn_next [DIV_UNITS][QBITS];
    logic [30:0]      dvq_reg  [DIV_UNITS][QBITS];
    logic [30:0]      dvq_next [DIV_UNITS][QBITS];
    logic [DEN_W-1:0] dvd_reg  [DIV_UNITS][QBITS];
    logic [DEN_W-1:0] dvd_next [DIV_UNITS][QBITS];

    // middle and tail
    logic [30:0]      t_abs;
    logic [30:0]      nrm;
    logic [30:0]      thr;
    logic             xneg_next;
    logic             xneg_dl [XDL_LEN];
    logic [30:0]      dmag_reg;
    logic [30:0]      dmag_next;
    logic [37:0]      xmag_reg;
    logic [37:0]      xmag_next;
    logic [DEN_W-1:0] qd_next;
    logic [DEN_W-1:0] qd_dl [QDL_LEN];
    logic [30:0]      t_dl [TDL_LEN];

    logic [30:0] sig;
    logic [30:0] qv;
    logic [30:0] t_late;
    logic [17:0] prob_full;
    logic [15:0] prob_next;
    logic [15:0] prob_reg [PROB_LEN];
    logic [28:0] dsig_reg;
    logic [28:0] dsig_next;
    logic [30:0] surr_reg;
    logic [30:0] surr_next;
    logic [30:0] t2_reg;
    logic [30:0] t2_next;
    logic [30:0] sq0_reg;
    logic [30:0] sq0_next;
    logic [30:0] surr2_reg;
    logic [28:0] dsig2_reg;
    logic [29:0] dtn_reg;
    logic [29:0] dtn_next;
    logic [29:0] dtn2_reg;
    logic [30:0] inner_reg;
    logic [30:0] inner_next;
    logic [29:0] m_reg;
    logic [29:0] m_next;
    logic [45:0] mg_reg;
    logic [45:0] mg_next;
    logic [61:0] pr_reg;
    logic [61:0] pr_next;
    logic [61:0] rnd;
    logic [27:0] mag;
    logic [15:0] fire_prob_reg;
    logic [15:0] fire_prob_next;
    logic [23:0] source_grad_reg;
    logic [23:0] source_grad_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= 16'd256;
            threshold_reg   <= 16'd32768;
            beta_reg        <= 16'd2560;
            source_size_reg <= DIM_W'(MAX_DIM);
            target_size_reg <= DIM_W'(MAX_DIM);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN:        gain_reg        <= cfg_data;
                REG_THRESHOLD:   threshold_reg   <= cfg_data;
                REG_BETA:        beta_reg        <= cfg_data;
                REG_SOURCE_SIZE: source_size_reg <= cfg_data[DIM_W-1:0];
                REG_TARGET_SIZE: target_size_reg <= cfg_data[DIM_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ST_OUT-1:0], start && !busy};
        end
    end

    // input stage
    always_comb
    begin
        dim = (source_size_reg < target_size_reg) ? source_size_reg : target_size_reg;
        if (dim > DIM_W'(MAX_DIM))
        begin
            dim = DIM_W'(MAX_DIM);
        end
        side_next.pad   = {1'b0, element_index} >= dim;
        side_next.s_neg = source_value[15];
        side_next.u_neg = upstream_grad[15];
        side_next.u_mag = upstream_grad[15] ? 16'(16'd0 - upstream_grad) : upstream_grad;
        smag_next       = source_value[15] ? 16'(16'd0 - source_value) : source_value;
    end

    // exponential units: e^-y in Q30
    always_comb
    begin
        logic [30:0] pp;
        ex_y[0] = {smag_reg, 23'd0};
        ex_y[1] = {1'b0, xmag_reg};
        for (int u = 0; u < EXP_UNITS; u++)
        begin
            ey_next[u]    = ex_y[u];
            ek_next[u][0] = '0;
            for (int j = 1; j < 31; j++)
            begin
                if (ex_y[u] >= 39'(ln2_mult(5'(j))))
                begin
                    ek_next[u][0] = 5'(j);
                end
            end
            ez_next[u][0] = ex_y[u] >= 39'(ln2_mult(5'd31));
            er_next[u][0] = 30'(ey_reg[u] - 39'(ln2_mult(ek_reg[u][0])));
            for (int s = 1; s < EXP_CARRY; s++)
            begin
                ek_next[u][s] = ek_reg[u][s-1];
                ez_next[u][s] = ez_reg[u][s-1];
            end
            for (int s = 1; s < ER_LEN; s++)
            begin
                er_next[u][s] = er_reg[u][s-1];
            end
            for (int h = 0; h < HORNER_STEPS; h++)
            begin
                if (h == 0)
                begin
                    pp = ONE_Q30;
                end
                else
                begin
                    pp = hp_reg[u][h-1];
                end
                hv_next[u][h] = 30'((61'(er_reg[u][3*h]) * 61'(pp)) >> 30);
                hw_next[u][h] = hv_reg[u][h];
                hq_next[u][h] = quot_est(31'(hv_reg[u][h]), 4'(HORNER_STEPS - h));
                hp_next[u][h] = ONE_Q30 - quot_fix(31'(hw_reg[u][h]), hq_reg[u][h],
                                                   4'(HORNER_STEPS - h));
            end
            e_next[u] = ez_reg[u][EXP_CARRY-1] ? '0
                      : hp_reg[u][HORNER_STEPS-1] >> ek_reg[u][EXP_CARRY-1];
        end
    end

    // restoring dividers, one quotient bit per stage
    always_comb
    begin
        logic [DEN_W-1:0] rp;
        logic [30:0]      nl;
        logic [30:0]      qp;
        logic [DEN_W-1:0] dd;
        logic [DEN_W:0]   trial;
        dv_n[0] = {31'(ONE_Q30 - e_reg[0]), 30'd0};
        dv_d[0] = DEN_W'(ONE_Q30) + DEN_W'(e_reg[0]);
        dv_n[1] = xneg_dl[XDL_LEN-1] ? {e_reg[1], 30'd0} : NUM_ONE;
        dv_d[1] = DEN_W'(ONE_Q30) + DEN_W'(e_reg[1]);
        dv_n[2] = NUM_ONE;
        dv_d[2] = qd_dl[QDL_LEN-1];
        for (int u = 0; u < DIV_UNITS; u++)
        begin
            for (int i = 0; i < QBITS; i++)
            begin
                if (i == 0)
                begin
                    rp = DEN_W'(dv_n[u][NUM_W-1:QBITS]);
                    nl = dv_n[u][QBITS-1:0];
                    qp = '0;
                    dd = dv_d[u];
                end
                else
                begin
                    rp = dvr_reg[u][i-1];
                    nl = dvn_reg[u][i-1];
                    qp = dvq_reg[u][i-1];
                    dd = dvd_reg[u][i-1];
                end
                trial = {rp, nl[30]};
                if (trial >= {1'b0, dd})
                begin
                    dvr_next[u][i] = DEN_W'(trial - {1'b0, dd});
                    dvq_next[u][i] = {qp[29:0], 1'b1};
                end
                else
                begin
                    dvr_next[u][i] = trial[DEN_W-1:0];
                    dvq_next[u][i] = {qp[29:0], 1'b0};
                end
                dvn_next[u][i] = {nl[29:0], 1'b0};
                dvd_next[u][i] = dd;
            end
        end
    end

    // sigmoid argument, surrogate denominator and gradient tail
    always_comb
    begin
        t_abs     = dvq_reg[0][QBITS-1];
        nrm       = side_reg[ST_T].s_neg ? 31'((32'(ONE_Q30) - 32'(t_abs)) >> 1)
                                         : 31'((32'(ONE_Q30) + 32'(t_abs)) >> 1);
        thr       = {1'b0, threshold_reg, 14'd0};
        xneg_next = nrm < thr;
        dmag_next = xneg_next ? thr - nrm : nrm - thr;
        xmag_next = 38'((47'(gain_reg) * 47'(dmag_reg)) >> 8);
        qd_next   = DEN_W'(ONE_Q30) + DEN_W'((54'(beta_reg) * 54'(xmag_reg)) >> 8);

        sig       = dvq_reg[1][QBITS-1];
        qv        = dvq_reg[2][QBITS-1];
        t_late    = t_dl[TDL_LEN-1];
        dsig_next = 29'((62'(sig) * 62'(ONE_Q30 - sig)) >> 30);
        surr_next = 31'((62'(qv) * 62'(qv)) >> 30);
        t2_next   = 31'((62'(t_late) * 62'(t_late)) >> 30);
        prob_full = 18'((32'(sig) + 32'd8192) >> 14);
        prob_next = (prob_full > 18'd65535) ? 16'hFFFF : prob_full[15:0];

        sq0_next   = quot_est(surr_reg, 4'd10);
        dtn_next   = 30'((ONE_Q30 - t2_reg) >> 1);
        inner_next = 31'(dsig2_reg) + quot_fix(surr2_reg, sq0_reg, 4'd10);
        m_next     = 30'((61'(inner_reg) * 61'(dtn2_reg)) >> 30);
        mg_next    = 46'(m_reg) * 46'(gain_reg);
        pr_next    = 62'(mg_reg) * 62'(side_reg[ST_OUT-2].u_mag);

        rnd = pr_reg + (62'd1 << 33);
        mag = rnd[61:34];
        if (side_reg[ST_OUT-1].pad)
        begin
            source_grad_next = '0;
            fire_prob_next   = '0;
        end
        else
        begin
            fire_prob_next = prob_reg[PROB_LEN-1];
            if (side_reg[ST_OUT-1].u_neg)
            begin
                source_grad_next = (mag > 28'd8388608) ? 24'h800000
                                                       : 24'(28'd0 - mag);
            end
            else
            begin
                source_grad_next = (mag > 28'd8388607) ? 24'h7FFFFF : mag[23:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        smag_reg    <= smag_next;
        for (int i = 1; i < ST_OUT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end

        ey_reg  <= ey_next;
        ek_reg  <= ek_next;
        ez_reg  <= ez_next;
        er_reg  <= er_next;
        hv_reg  <= hv_next;
        hw_reg  <= hw_next;
        hq_reg  <= hq_next;
        hp_reg  <= hp_next;
        e_reg   <= e_next;

        dvr_reg <= dvr_next;
        dvn_reg <= dvn_next;
        dvq_reg <= dvq_next;
        dvd_reg <= dvd_next;

        dmag_reg   <= dmag_next;
        xneg_dl[0] <= xneg_next;
        for (int i = 1; i < XDL_LEN; i++)
        begin
            xneg_dl[i] <= xneg_dl[i-1];
        end
        t_dl[0] <= t_abs;
        for (int i = 1; i < TDL_LEN; i++)
        begin
            t_dl[i] <= t_dl[i-1];
        end
        xmag_reg <= xmag_next;
        qd_dl[0] <= qd_next;
        for (int i = 1; i < QDL_LEN; i++)
        begin
            qd_dl[i] <= qd_dl[i-1];
        end

        dsig_reg    <= dsig_next;
        surr_reg    <= surr_next;
        t2_reg      <= t2_next;
        prob_reg[0] <= prob_next;
        for (int i = 1; i < PROB_LEN; i++)
        begin
            prob_reg[i] <= prob_reg[i-1];
        end
        sq0_reg   <= sq0_next;
        surr2_reg <= surr_reg;
        dsig2_reg <= dsig_reg;
        dtn_reg   <= dtn_next;
        inner_reg <= inner_next;
        dtn2_reg  <= dtn_reg;
        m_reg     <= m_next;
        mg_reg    <= mg_next;
        pr_reg    <= pr_next;

        fire_prob_reg   <= fire_prob_next;
        source_grad_reg <= source_grad_next;
    end

    assign done        = vld_reg[ST_OUT];
    assign fire_prob   = fire_prob_reg;
    assign source_grad = source_grad_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
class encoder_scoreboard;
    logic [15:0] prob_q[$];
    logic [23:0] grad_q[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    function void note_element(logic [15:0] p, logic [23:0] g);
        prob_q.push_back(p);
        grad_q.push_back(g);
    endfunction

    function int pending();
        return prob_q.size();
    endfunction

    function void report(string msg);
        $display("MISMATCH %0t: %s", $time, msg);
        errors++;
    endfunction

    function void check_result(logic [15:0] p, logic [23:0] g);
        logic [15:0] ep;
        logic [23:0] eg;
        if (prob_q.size() == 0)
        begin
            report($sformatf("unexpected result prob=%0d grad=%0d", p, g));
            return;
        end
        ep = prob_q.pop_front();
        eg = grad_q.pop_front();
        if (p !== ep)
            report($sformatf("fire_prob got %0d exp %0d", p, ep));
        if (g !== eg)
            report($sformatf("source_grad got %0h exp %0h", g, eg));
    endfunction
endclass

module tb_top;
    import tsse_pkg::*;

    localparam logic [63:0] ONE = 64'd1 << 30;
    localparam logic [63:0] LN2 = 64'd744261118;
    localparam logic [2:0]  REG_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [11:0] element_index;
    logic signed [15:0] source_value;
    logic signed [15:0] upstream_grad;
    logic done;
    logic [15:0] fire_prob;
    logic signed [23:0] source_grad;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    logic [63:0] m_gain, m_thr, m_beta, m_src, m_tgt;
    encoder_scoreboard sb;
    int n_items, n_results;

    tanh_sigmoid_spike_encoder_gradient_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] exp_neg_q30(logic [63:0] y);
        logic [63:0] k, r, p;
        k = y / LN2;
        r = y - k * LN2;
        p = ONE;
        if (k > 30)
            return 0;
        for (int n = 9; n >= 1; n--)
            p = ONE - ((r * p) >> 30) / n;
        return p >> k;
    endfunction

    function automatic void predict_encoding(logic [11:0] idx, logic [15:0] sv,
                                             logic [15:0] ug, output logic [15:0] prob_o,
                                             output logic [23:0] grad_o);
        logic [63:0] dim, s_mag, u_mag, e, t_abs, nv, thr, d_mag, x_mag, sig, prob;
        logic [63:0] dsig, q, surr, inner, t2, dn, m, mag;
        logic s_neg, u_neg, x_neg;
        dim = m_src < m_tgt ? m_src : m_tgt;
        if (dim > MAX_DIM)
            dim = MAX_DIM;
        if (idx >= dim)
        begin
            prob_o = 0;
            grad_o = 0;
            return;
        end
        s_neg = sv[15];
        s_mag = s_neg ? 64'h10000 - sv : sv;
        u_neg = ug[15];
        u_mag = u_neg ? 64'h10000 - ug : ug;
        e = exp_neg_q30(s_mag << 23);
        t_abs = ((ONE - e) << 30) / (ONE + e);
        nv = s_neg ? (ONE - t_abs) >> 1 : (ONE + t_abs) >> 1;
        thr = m_thr << 14;
        x_neg = nv < thr;
        d_mag = x_neg ? thr - nv : nv - thr;
        x_mag = (m_gain * d_mag) >> 8;
        e = exp_neg_q30(x_mag);
        sig = x_neg ? (e << 30) / (ONE + e) : (ONE << 30) / (ONE + e);
        prob = (sig + 8192) >> 14;
        if (prob > 65535)
            prob = 65535;
        dsig = (sig * (ONE - sig)) >> 30;
        q = (ONE << 30) / (ONE + ((m_beta * x_mag) >> 8));
        surr = (q * q) >> 30;
        inner = dsig + surr / 10;
        t2 = (t_abs * t_abs) >> 30;
        dn = (ONE - t2) >> 1;
        m = (inner * dn) >> 30;
        mag = (m * m_gain * u_mag + (64'd1 << 33)) >> 34;
        prob_o = prob[15:0];
        if (u_neg)
        begin
            if (mag > 8388608)
                mag = 8388608;
            grad_o = 24'((64'h1000000 - mag) & 64'hFFFFFF);
        end
        else
        begin
            if (mag > 8388607)
                mag = 8388607;
            grad_o = mag[23:0];
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(fire_prob, source_grad);
            n_results++;
        end
    end

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_GAIN:        m_gain = 64'(val);
            REG_THRESHOLD:   m_thr = 64'(val);
            REG_BETA:        m_beta = 64'(val);
            REG_SOURCE_SIZE: m_src = 64'(val & 16'h1FFF);
            REG_TARGET_SIZE: m_tgt = 64'(val & 16'h1FFF);
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_element(logic [11:0] idx, logic [15:0] sv, logic [15:0] ug,
                                bit allow_idle);
        logic [15:0] p;
        logic [23:0] g;
        if (allow_idle && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        element_index <= idx;
        source_value <= sv;
        upstream_grad <= ug;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_encoding(idx, sv, ug, p, g);
        sb.note_element(p, g);
        n_items++;
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(int count, bit idle);
        logic [15:0] sv;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: sv = 16'($urandom);
                1: sv = 16'($signed($urandom_range(0, 2047)) - 1024);
                2: sv = 16'($signed($urandom_range(0, 255)) - 128);
                default: sv = {16{$urandom_range(0, 1) == 1}} ^ 16'($urandom_range(0, 15));
            endcase
            send_element($urandom_range(0, 3) == 0 ? 12'($urandom) :
                         12'($urandom_range(0, 63)), sv, 16'($urandom), idle);
        end
        end_burst();
    endtask

    initial
    begin
        logic [15:0] dir_sv[10];
        sb = new();
        n_items = 0;
        n_results = 0;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        element_index = '0;
        source_value = '0;
        upstream_grad = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_gain = 256;
        m_thr = 32768;
        m_beta = 2560;
        m_src = 4096;
        m_tgt = 4096;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_sv = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                   16'h0100, 16'hFF00, 16'h0080, 16'hFF80, 16'h0400};
        foreach (dir_sv[i])
            send_element(12'(i), dir_sv[i], (i % 2) ? 16'h8000 : 16'h7FFF, 1'b0);
        send_element(12'hFFF, 16'h0100, 16'h1000, 1'b0);
        send_element(12'd5, 16'h0100, 16'h0000, 1'b0);
        send_element(12'd6, 16'h0100, 16'hFFFF, 1'b0);
        end_burst();
        wait_drained();

        write_reg(REG_GAIN, 16'hFFFF);
        write_reg(REG_THRESHOLD, 16'h0000);
        write_reg(REG_BETA, 16'h0000);
        write_reg(REG_SOURCE_SIZE, 16'd0);
        write_reg(REG_TARGET_SIZE, 16'd4096);
        send_element(12'd0, 16'h0100, 16'h7FFF, 1'b0);
        end_burst();
        wait_drained();
        write_reg(REG_SOURCE_SIZE, 16'd8191);
        foreach (dir_sv[i])
            send_element(12'(i * 400), dir_sv[i], 16'h7FFF, 1'b0);
        end_burst();
        wait_drained();
        write_reg(REG_THRESHOLD, 16'hFFFF);
        write_reg(REG_BETA, 16'hFFFF);
        write_reg(REG_GAIN, 16'd0);
        write_reg(REG_UNUSED, 16'h1234);
        random_phase(200, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_GAIN, ph == 0 ? 16'd1 : 16'($urandom));
            write_reg(REG_THRESHOLD, 16'($urandom));
            write_reg(REG_BETA, 16'($urandom));
            write_reg(REG_SOURCE_SIZE, 16'($urandom_range(0, 80)));
            write_reg(REG_TARGET_SIZE, ph == 1 ? 16'd4096 : 16'($urandom_range(0, 8191)));
            random_phase(ph == 4 ? 200 : 220, ph != 4);
            wait_drained();
        end
        write_reg(REG_GAIN, 16'd256);
        write_reg(REG_THRESHOLD, 16'd32768);
        write_reg(REG_BETA, 16'd2560);
        random_phase(200, 1'b0);
        wait_drained();

        $display("Covered %0d elements, %0d results, register extremes and padding.",
                 n_items, n_results);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end
endmodule
